### rtl/infix_expression_evaluator_core_defines.svh
// ----------------------------------------------------------------------------
// Infix expression evaluator: assertion macros
// Concurrent assertion forms used by the evaluator back end.
// ----------------------------------------------------------------------------
`ifndef INFIX_EXPRESSION_EVALUATOR_CORE_DEFINES_SVH
`define INFIX_EXPRESSION_EVALUATOR_CORE_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define IED_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is checked on every edge, reset included.
`define IED_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/ied_pkg.sv
// ----------------------------------------------------------------------------
// Infix expression evaluator: package
// Symbol and operator codes, the token passed from front to back, the
// sequencer states and the fixed-point helper functions.
// ----------------------------------------------------------------------------
package ied_pkg;

   localparam logic [3:0] SYM_LAST_DIGIT = 4'd9;
   localparam logic [3:0] SYM_POINT      = 4'd10;
   localparam logic [3:0] SYM_ADD        = 4'd11;
   localparam logic [3:0] SYM_DIV        = 4'd14;

   localparam logic [3:0] MAX_FRAC_DIGITS = 4'd9;

   localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef struct packed {
      logic [63:0] mant;
      logic [3:0]  frac;
      logic        has_op;
      op_type      op;
      logic        is_end;
   } tok_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CONV,
      S_CHECK,
      S_RED,
      S_MUL,
      S_DIV,
      S_OUT
   } state_type;

   function automatic logic [63:0] pow10(input logic [3:0] n);
      logic [63:0] p;
      unique case (n)
         4'd0:    p = 64'd1;
         4'd1:    p = 64'd10;
         4'd2:    p = 64'd100;
         4'd3:    p = 64'd1000;
         4'd4:    p = 64'd10000;
         4'd5:    p = 64'd100000;
         4'd6:    p = 64'd1000000;
         4'd7:    p = 64'd10000000;
         4'd8:    p = 64'd100000000;
         default: p = 64'd1000000000;
      endcase
      return p;
   endfunction

   function automatic logic [63:0] mag(input logic [63:0] x);
      return x[63] ? (64'd0 - x) : x;
   endfunction

   function automatic logic [63:0] signed_sat(input logic [63:0] m, input logic neg,
                                              input logic ovf);
      logic [63:0] r;
      if (neg) begin
         r = (ovf || m > SMIN) ? SMIN : (64'd0 - m);
      end else begin
         r = (ovf || m > SMAX) ? SMAX : m;
      end
      return r;
   endfunction

   function automatic logic [63:0] fx_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         s = a[63] ? SMIN : SMAX;
      end
      return s;
   endfunction

   function automatic logic [63:0] fx_sub(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] d;
      d = a - b;
      if (a[63] != b[63] && d[63] != a[63]) begin
         d = a[63] ? SMIN : SMAX;
      end
      return d;
   endfunction

endpackage

### rtl/ied_channels.sv
// ----------------------------------------------------------------------------
// Infix expression evaluator: channel interfaces
// Valid/ready channels for incoming symbols and outgoing results.
// ----------------------------------------------------------------------------
interface ied_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] symbol;
   logic       end_of_expr;

   modport source (output valid, symbol, end_of_expr, input ready);
   modport sink   (input valid, symbol, end_of_expr, output ready);
endinterface

interface ied_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] value;
   logic               div_zero;

   modport source (output valid, value, div_zero, input ready);
   modport sink   (input valid, value, div_zero, output ready);
endinterface

### rtl/ied_div.sv
// ----------------------------------------------------------------------------
// Infix expression evaluator: iterative divider
// Restoring divider for (x << FRAC_BITS) / d, one quotient bit per cycle.
// Quotient bits above bit 63 are folded into an overflow flag.
// ----------------------------------------------------------------------------
module ied_div #(
   parameter int FRAC_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] x,
   input  logic [63:0] d,
   output logic        done,
   output logic [63:0] q,
   output logic        ovf
);
   localparam int STEPS = 64 + FRAC_BITS;
   localparam int CW    = $clog2(STEPS + 1);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [63:0]   x_ff, x_in;
   logic [63:0]   d_ff, d_in;
   logic [63:0]   rem_ff, rem_in;
   logic [63:0]   q_ff, q_in;
   logic          ovf_ff, ovf_in;
   logic [64:0]   rem_sh;
   logic          ge;

   always_comb begin
      rem_sh  = {rem_ff, x_ff[63]};
      ge      = rem_sh >= {1'b0, d_ff};
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      x_in    = x_ff;
      d_in    = d_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         cnt_in = CW'(STEPS);
         run_in = 1'b1;
         x_in   = x;
         d_in   = d;
         rem_in = '0;
         q_in   = '0;
         ovf_in = 1'b0;
      end else if (run_ff) begin
         // The dividend is x followed by FRAC_BITS zeros; x shifts out at the top.
         x_in   = {x_ff[62:0], 1'b0};
         rem_in = ge ? 64'(rem_sh - {1'b0, d_ff}) : rem_sh[63:0];
         q_in   = {q_ff[62:0], ge};
         ovf_in = ovf_ff | q_ff[63];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff   <= x_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
   end

   assign done = done_ff;
   assign q    = q_ff;
   assign ovf  = ovf_ff;
endmodule

### rtl/ied_front.sv
// ----------------------------------------------------------------------------
// Infix expression evaluator: front end
// Accepts symbols, builds the decimal mantissa, and emits a token for each
// operator or end of expression.
// ----------------------------------------------------------------------------
module ied_front (
   input  logic            clock,
   input  logic            reset,
   ied_req_if.sink         req_chan,
   input  logic            q_full,
   output logic            tok_push,
   output ied_pkg::tok_type tok
);
   import ied_pkg::*;

   logic [63:0] mant_ff, mant_in;
   logic [3:0]  frac_ff, frac_in;
   logic        point_ff, point_in;
   logic [63:0] mant_nx;
   logic [3:0]  frac_nx;
   logic [67:0] times10;
   logic        accept;
   logic        is_digit;
   logic        is_op;
   logic [3:0]  op_diff;

   assign req_chan.ready = !q_full;
   assign accept   = req_chan.valid && req_chan.ready;
   assign is_digit = req_chan.symbol <= SYM_LAST_DIGIT;
   assign is_op    = req_chan.symbol >= SYM_ADD && req_chan.symbol <= SYM_DIV;
   assign op_diff  = req_chan.symbol - SYM_ADD;

   always_comb begin
      times10 = ({4'd0, mant_ff} << 3) + ({4'd0, mant_ff} << 1)
              + {64'd0, req_chan.symbol};
      mant_nx = mant_ff;
      frac_nx = frac_ff;
      if (is_digit && (!point_ff || frac_ff < MAX_FRAC_DIGITS)) begin
         mant_nx = (times10[67:64] != 4'd0) ? '1 : times10[63:0];
         if (point_ff) begin
            frac_nx = frac_ff + 4'd1;
         end
      end
   end

   always_comb begin
      tok.mant   = mant_nx;
      tok.frac   = frac_nx;
      tok.has_op = is_op;
      tok.op     = op_type'(op_diff[1:0]);
      tok.is_end = req_chan.end_of_expr;
      tok_push   = accept && (is_op || req_chan.end_of_expr);
   end

   always_comb begin
      mant_in  = mant_ff;
      frac_in  = frac_ff;
      point_in = point_ff;
      if (accept) begin
         if (is_op || req_chan.end_of_expr) begin
            mant_in  = '0;
            frac_in  = '0;
            point_in = 1'b0;
         end else begin
            mant_in  = mant_nx;
            frac_in  = frac_nx;
            point_in = point_ff || (req_chan.symbol == SYM_POINT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mant_ff  <= '0;
         frac_ff  <= '0;
         point_ff <= 1'b0;
      end else begin
         mant_ff  <= mant_in;
         frac_ff  <= frac_in;
         point_ff <= point_in;
      end
   end
endmodule

### rtl/ied_fifo.sv
// ----------------------------------------------------------------------------
// Infix expression evaluator: token queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module ied_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ied_pkg::tok_type din,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output ied_pkg::tok_type head
);
   import ied_pkg::*;

   tok_type    mem [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full  = cnt_ff == 2'd2;
   assign valid = cnt_ff != 2'd0;
   assign head  = mem[rd_ff];

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

### rtl/ied_back.sv
// ----------------------------------------------------------------------------
// Infix expression evaluator: back end
// Sequencer over the number and operator stacks. Converts each number,
// reduces by precedence and drives the result register.
// ----------------------------------------------------------------------------
`include "infix_expression_evaluator_core_defines.svh"

module ied_back #(
   parameter int FRAC_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             tok_valid,
   input  ied_pkg::tok_type tok,
   output logic             tok_pop,
   ied_rsp_if.source        rsp_chan
);
   import ied_pkg::*;

   state_type    state_ff, state_in;
   logic [63:0]  num_ff [3];
   logic [63:0]  num_in [3];
   logic [1:0]   num_cnt_ff, num_cnt_in;
   op_type       op_ff [2];
   op_type       op_in [2];
   logic [1:0]   op_cnt_ff, op_cnt_in;
   logic         err_ff, err_in;
   logic         phase_end_ff, phase_end_in;
   logic [2:0]   mul_step_ff, mul_step_in;
   logic [63:0]  pp_ff, pp_in;
   logic [1:0]   sh_ff, sh_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  opa_ff, opa_in;
   logic [63:0]  opb_ff, opb_in;
   logic         neg_ff, neg_in;
   logic         rsp_v_ff, rsp_v_in;
   logic [63:0]  rsp_val_ff, rsp_val_in;
   logic         rsp_dz_ff, rsp_dz_in;

   logic         div_start;
   logic [63:0]  div_x, div_d;
   logic         div_done;
   logic [63:0]  div_q;
   logic         div_ovf;

   op_type       op_top;
   logic [63:0]  num_a, num_b;
   logic         want_red;
   logic [63:0]  conv_val, div_res, mul_res;
   logic [31:0]  mx, my;

   ied_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .x     (div_x),
      .d     (div_d),
      .done  (div_done),
      .q     (div_q),
      .ovf   (div_ovf)
   );

   assign op_top   = (op_cnt_ff == 2'd2) ? op_ff[1] : op_ff[0];
   assign num_b    = (num_cnt_ff == 2'd3) ? num_ff[2] : num_ff[1];
   assign num_a    = (num_cnt_ff == 2'd3) ? num_ff[1] : num_ff[0];
   // Reduce while the stacked operator binds at least as tightly, or always at the end.
   assign want_red = op_cnt_ff != 2'd0 && num_cnt_ff >= 2'd2
                     && (phase_end_ff || op_top[1] >= tok.op[1]);
   assign conv_val = (div_ovf || div_q[63]) ? SMAX : div_q;
   assign div_res  = signed_sat(div_q, neg_ff, div_ovf);
   assign mul_res  = signed_sat(acc_ff[FRAC_BITS +: 64], neg_ff,
                                (acc_ff >> (64 + FRAC_BITS)) != 128'd0);
   assign mx       = mul_step_ff[1] ? opa_ff[63:32] : opa_ff[31:0];
   assign my       = mul_step_ff[0] ? opb_ff[63:32] : opb_ff[31:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (tok_valid) begin
               if (err_ff) begin
                  state_in = tok.is_end ? S_OUT : S_IDLE;
               end else begin
                  state_in = S_CONV;
               end
            end
         end
         S_CONV: begin
            if (div_done) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (want_red) begin
               state_in = S_RED;
            end else if (!phase_end_ff) begin
               state_in = tok.is_end ? S_CHECK : S_IDLE;
            end else begin
               state_in = S_OUT;
            end
         end
         S_RED: begin
            unique case (op_top)
               OP_ADD, OP_SUB: state_in = S_CHECK;
               OP_MUL:         state_in = S_MUL;
               default: begin
                  if (num_b == 64'd0) begin
                     state_in = tok.is_end ? S_OUT : S_IDLE;
                  end else begin
                     state_in = S_DIV;
                  end
               end
            endcase
         end
         S_MUL: begin
            if (mul_step_ff == 3'd5) begin
               state_in = S_CHECK;
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_CHECK;
            end
         end
         default: begin
            if (rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      num_in       = num_ff;
      num_cnt_in   = num_cnt_ff;
      op_in        = op_ff;
      op_cnt_in    = op_cnt_ff;
      err_in       = err_ff;
      phase_end_in = phase_end_ff;
      mul_step_in  = mul_step_ff;
      pp_in        = pp_ff;
      sh_in        = sh_ff;
      acc_in       = acc_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      neg_in       = neg_ff;
      rsp_v_in     = rsp_v_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_dz_in    = rsp_dz_ff;
      div_start    = 1'b0;
      div_x        = '0;
      div_d        = '0;
      tok_pop      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (tok_valid) begin
               if (err_ff) begin
                  if (tok.is_end) begin
                     rsp_v_in   = 1'b1;
                     rsp_val_in = '0;
                     rsp_dz_in  = 1'b1;
                  end else begin
                     tok_pop = 1'b1;
                  end
               end else begin
                  // Number entry: (mantissa << FRAC_BITS) / 10^digits on the divider.
                  div_start    = 1'b1;
                  div_x        = tok.mant;
                  div_d        = pow10(tok.frac);
                  phase_end_in = !tok.has_op;
               end
            end
         end
         S_CONV: begin
            if (div_done && num_cnt_ff != 2'd3) begin
               num_in[num_cnt_ff] = conv_val;
               num_cnt_in         = num_cnt_ff + 2'd1;
            end
         end
         S_CHECK: begin
            if (want_red) begin
               // Nothing to do here; the reduction starts next cycle.
            end else if (!phase_end_ff) begin
               if (op_cnt_ff != 2'd2) begin
                  op_in[op_cnt_ff[0]] = tok.op;
                  op_cnt_in           = op_cnt_ff + 2'd1;
               end
               if (tok.is_end) begin
                  // The operand after a trailing operator is zero.
                  phase_end_in = 1'b1;
                  if (num_cnt_ff != 2'd3) begin
                     num_in[num_cnt_ff] = '0;
                     num_cnt_in         = num_cnt_ff + 2'd1;
                  end
               end else begin
                  tok_pop = 1'b1;
               end
            end else begin
               rsp_v_in   = 1'b1;
               rsp_dz_in  = 1'b0;
               rsp_val_in = (num_cnt_ff == 2'd0) ? 64'd0 : num_ff[num_cnt_ff - 2'd1];
            end
         end
         S_RED: begin
            op_cnt_in = op_cnt_ff - 2'd1;
            neg_in    = num_a[63] ^ num_b[63];
            opa_in    = mag(num_a);
            opb_in    = mag(num_b);
            unique case (op_top)
               OP_ADD: begin
                  num_cnt_in                    = num_cnt_ff - 2'd1;
                  num_in[num_cnt_ff - 2'd2]     = fx_add(num_a, num_b);
               end
               OP_SUB: begin
                  num_cnt_in                    = num_cnt_ff - 2'd1;
                  num_in[num_cnt_ff - 2'd2]     = fx_sub(num_a, num_b);
               end
               OP_MUL: begin
                  num_cnt_in  = num_cnt_ff - 2'd2;
                  acc_in      = '0;
                  mul_step_in = '0;
               end
               default: begin
                  num_cnt_in = num_cnt_ff - 2'd2;
                  if (num_b == 64'd0) begin
                     err_in = 1'b1;
                     if (tok.is_end) begin
                        rsp_v_in   = 1'b1;
                        rsp_val_in = '0;
                        rsp_dz_in  = 1'b1;
                     end else begin
                        tok_pop = 1'b1;
                     end
                  end else begin
                     div_start = 1'b1;
                     div_x     = mag(num_a);
                     div_d     = mag(num_b);
                  end
               end
            endcase
         end
         S_MUL: begin
            // Four 32x32 partial products, each registered before it is accumulated.
            mul_step_in = mul_step_ff + 3'd1;
            if (mul_step_ff < 3'd4) begin
               pp_in = mx * my;
               sh_in = {1'b0, mul_step_ff[1]} + {1'b0, mul_step_ff[0]};
            end
            if (mul_step_ff != 3'd0 && mul_step_ff != 3'd5) begin
               acc_in = acc_ff + ({64'd0, pp_ff} << {sh_ff, 5'd0});
            end
            if (mul_step_ff == 3'd5 && num_cnt_ff != 2'd3) begin
               num_in[num_cnt_ff] = mul_res;
               num_cnt_in         = num_cnt_ff + 2'd1;
            end
         end
         S_DIV: begin
            if (div_done && num_cnt_ff != 2'd3) begin
               num_in[num_cnt_ff] = div_res;
               num_cnt_in         = num_cnt_ff + 2'd1;
            end
         end
         default: begin
            if (rsp_chan.ready) begin
               rsp_v_in     = 1'b0;
               num_cnt_in   = '0;
               op_cnt_in    = '0;
               err_in       = 1'b0;
               phase_end_in = 1'b0;
               tok_pop      = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         num_cnt_ff   <= '0;
         op_cnt_ff    <= '0;
         err_ff       <= 1'b0;
         phase_end_ff <= 1'b0;
         rsp_v_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         num_cnt_ff   <= num_cnt_in;
         op_cnt_ff    <= op_cnt_in;
         err_ff       <= err_in;
         phase_end_ff <= phase_end_in;
         rsp_v_ff     <= rsp_v_in;
      end
      for (int i = 0; i < 3; i++) begin
         num_ff[i] <= num_in[i];
      end
      for (int i = 0; i < 2; i++) begin
         op_ff[i] <= op_in[i];
      end
      mul_step_ff <= mul_step_in;
      pp_ff       <= pp_in;
      sh_ff       <= sh_in;
      acc_ff      <= acc_in;
      opa_ff      <= opa_in;
      opb_ff      <= opb_in;
      neg_ff      <= neg_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_dz_ff   <= rsp_dz_in;
   end

   assign rsp_chan.valid    = rsp_v_ff;
   assign rsp_chan.value    = rsp_val_ff;
   assign rsp_chan.div_zero = rsp_dz_ff;

   `IED_ASSERT(a_red_operands, clock, reset, (state_ff == S_RED) |-> (num_cnt_ff >= 2'd2), "reduction without two operands")
   `IED_ASSERT(a_dz_value, clock, reset, (rsp_v_ff && rsp_dz_ff) |-> (rsp_val_ff == 64'd0), "divide-by-zero result is not zero")
   `IED_ASSERT(a_op_depth, clock, reset, (state_ff == S_CHECK) |-> (op_cnt_ff != 2'd3), "operator stack overrun")
endmodule

### rtl/infix_expression_evaluator_core.sv
// A digit or point symbol is absorbed in the front end.
// An operator or final symbol has its number converted on the shared restoring divider and
// placed, plus up to two reductions (add/sub, mul, div).
// A result is registered from the check state after the last reduction and holds until the receiver takes it.
// Throughput: the front end takes a symbol every cycle while the two-entry token queue has room.
// Reset: synchronous, active high; clears the stacks, the digit entry state and the result.
// ----------------------------------------------------------------------------
// Infix expression evaluator core
// Two-stack evaluator of decimal fixed-point expressions with + - * /.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_core #(
   parameter int FRAC_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   ied_req_if.sink   req_chan,
   ied_rsp_if.source rsp_chan
);
   import ied_pkg::*;

   logic    tok_push;
   tok_type tok_in;
   logic    q_full;
   logic    tok_pop;
   logic    tok_valid;
   tok_type tok_head;

   ied_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .tok_push (tok_push),
      .tok      (tok_in)
   );

   ied_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (tok_push),
      .din   (tok_in),
      .full  (q_full),
      .pop   (tok_pop),
      .valid (tok_valid),
      .head  (tok_head)
   );

   ied_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (tok_valid),
      .tok       (tok_head),
      .tok_pop   (tok_pop),
      .rsp_chan  (rsp_chan)
   );
endmodule

### verif/ied_checker.sv
// ----------------------------------------------------------------------------
// Infix evaluator result checker
// Watches both channels, computes each expression's value from the accepted
// symbols and compares it with the returned result, field by field.
// ----------------------------------------------------------------------------
module ied_checker
   import ied_pkg::*;
#(
   parameter int FRAC_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   ied_req_if.sink req_mon,
   ied_rsp_if.sink rsp_mon,
   output int      fail_count,
   output int      pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [63:0] value;
      logic        div_zero;
   } result_type;

   result_type  expected_results[$];

   logic [63:0] nums[3];
   int          num_depth;
   op_type      ops[2];
   int          op_depth;
   logic [63:0] digits_acc;
   logic [3:0]  frac_count;
   logic        point_flag;
   logic        zero_div;

   function automatic logic [63:0] ten_pow(input logic [3:0] n);
      logic [63:0] p;
      p = 64'd1;
      for (int i = 0; i < n; i++) p = p * 64'd10;
      return p;
   endfunction

   function automatic logic [63:0] sat_sign(input logic [63:0] m, input logic neg,
                                            input logic ovf);
      if (neg) return (ovf || m > 64'h8000_0000_0000_0000) ?
                      64'h8000_0000_0000_0000 : -m;
      return (ovf || m > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : m;
   endfunction

   function automatic logic [63:0] abs64(input logic [63:0] x);
      return x[63] ? -x : x;
   endfunction

   function automatic logic [63:0] fixed_arith(input op_type op, input logic [63:0] a,
                                               input logic [63:0] b);
      logic [127:0] wide;
      logic [63:0]  r;
      logic         neg;
      neg = a[63] ^ b[63];
      case (op)
         OP_ADD: begin
            r = a + b;
            if (a[63] == b[63] && r[63] != a[63])
               r = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
         end
         OP_SUB: begin
            r = a - b;
            if (a[63] != b[63] && r[63] != a[63])
               r = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
         end
         OP_MUL: begin
            wide = {64'd0, abs64(a)} * {64'd0, abs64(b)};
            wide = wide >> FRAC_BITS;
            r = sat_sign(wide[63:0], neg, wide[127:64] != 0);
         end
         default: begin
            wide = ({64'd0, abs64(a)} << FRAC_BITS) / {64'd0, abs64(b)};
            r = sat_sign(wide[63:0], neg, wide[127:64] != 0);
         end
      endcase
      return r;
   endfunction

   task automatic clear_expr();
      num_depth  = 0;
      op_depth   = 0;
      digits_acc = 0;
      frac_count = 0;
      point_flag = 0;
      zero_div   = 0;
   endtask

   task automatic push_entered_number();
      logic [63:0] p, ip, fp, v;
      p  = ten_pow(frac_count);
      ip = digits_acc / p;
      fp = digits_acc % p;
      if (ip > (64'h7FFF_FFFF_FFFF_FFFF >> FRAC_BITS)) v = 64'h7FFF_FFFF_FFFF_FFFF;
      else v = (ip << FRAC_BITS) + (fp << FRAC_BITS) / p;
      if (num_depth < 3) begin
         nums[num_depth] = v;
         num_depth++;
      end
      digits_acc = 0;
      frac_count = 0;
      point_flag = 0;
   endtask

   task automatic reduce_top();
      logic [63:0] a, b;
      op_type      op;
      if (op_depth == 0 || num_depth < 2) return;
      op_depth--;
      op = ops[op_depth];
      b = nums[num_depth - 1];
      a = nums[num_depth - 2];
      num_depth -= 2;
      if (op == OP_DIV && b == 0) begin
         zero_div = 1;
         return;
      end
      nums[num_depth] = fixed_arith(op, a, b);
      num_depth++;
   endtask

   task automatic take_symbol(input logic [3:0] sym, input logic last);
      result_type  r;
      logic [63:0] d;
      op_type      op;
      if (!zero_div) begin
         d = {60'd0, sym};
         if (sym <= SYM_LAST_DIGIT) begin
            if (!point_flag || frac_count < MAX_FRAC_DIGITS) begin
               if (digits_acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 10)
                  digits_acc = 64'hFFFF_FFFF_FFFF_FFFF;
               else digits_acc = digits_acc * 10 + d;
               if (point_flag) frac_count++;
            end
         end else if (sym == SYM_POINT) begin
            point_flag = 1;
         end else if (sym <= SYM_DIV) begin
            op = op_type'(sym - SYM_ADD);
            push_entered_number();
            while (!zero_div && op_depth > 0 && ops[op_depth - 1][1] >= op[1])
               reduce_top();
            if (!zero_div && op_depth < 2) begin
               ops[op_depth] = op;
               op_depth++;
            end
         end
      end
      if (!last) return;
      if (!zero_div) begin
         push_entered_number();
         while (!zero_div && op_depth > 0) reduce_top();
      end
      r.div_zero = zero_div;
      r.value    = (zero_div || num_depth == 0) ? 64'd0 : nums[num_depth - 1];
      expected_results.push_back(r);
      clear_expr();
   endtask

   always @(posedge clock) begin
      result_type exp_r;
      int         errs;
      errs = 0;
      if (reset) begin
         clear_expr();
         expected_results.delete();
         fail_count <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            take_symbol(req_mon.symbol, req_mon.end_of_expr);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               $error("result transfer with nothing expected: value=%h", rsp_mon.value);
               errs++;
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_mon.value !== exp_r.value) begin
                  $error("value: expected %h, got %h", exp_r.value, rsp_mon.value);
                  errs++;
               end
               if (rsp_mon.div_zero !== exp_r.div_zero) begin
                  $error("div_zero: expected %b, got %b", exp_r.div_zero,
                         rsp_mon.div_zero);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
      pending_count <= expected_results.size();
   end
endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// Infix evaluator testbench
// Feeds directed and random expressions with random gaps and receiver
// stalls, including one long stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
   import ied_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   idle_cycles;
   bit   long_hold;
   bit   sending_done;

   ied_req_if req_chan ();
   ied_rsp_if rsp_chan ();

   infix_expression_evaluator_core #(.FRAC_BITS(32)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   ied_checker #(.FRAC_BITS(32)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan.sink),
      .rsp_mon       (rsp_chan.sink),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // One symbol transfer; the gap before it is drawn per symbol. Valid stays
   // high between back-to-back symbols and drops only for a gap.
   task automatic send_symbol(input logic [3:0] sym, input logic last);
      int gap;
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_chan.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1;
      req_chan.symbol      <= sym;
      req_chan.end_of_expr <= last;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_number(input int ndig);
      for (int i = 0; i < ndig; i++) send_symbol(4'($urandom_range(0, 9)), 0);
      if ($urandom_range(0, 2) == 0) begin
         send_symbol(SYM_POINT, 0);
         repeat ($urandom_range(0, 5)) send_symbol(4'($urandom_range(0, 9)), 0);
      end
   endtask

   task automatic send_expression();
      int nops;
      nops = $urandom_range(0, 4);
      for (int k = 0; k <= nops; k++) begin
         send_number($urandom_range(0, 4));
         if (k < nops) send_symbol(4'($urandom_range(SYM_ADD, SYM_DIV)), 0);
      end
      send_symbol(4'($urandom_range(0, 9)), 1);
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) send_symbol(4'($urandom_range(0, 15)), i == n - 1);
   endtask

   task automatic send_list(input logic [3:0] syms[$]);
      foreach (syms[i]) send_symbol(syms[i], i == syms.size() - 1);
   endtask

   // Result side: random stalls, one long hold-off while symbols keep coming.
   initial begin
      int stall;
      rsp_chan.ready <= 0;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_chan.ready <= 0;
            repeat (3000) @(posedge clock);
            long_hold = 0;
         end
         stall = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_chan.ready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             long_hold)
            idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      int quiet;
      reset                = 1;
      sending_done         = 0;
      long_hold            = 0;
      req_chan.valid       = 0;
      req_chan.symbol      = 0;
      req_chan.end_of_expr = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: largest mantissa, extra fraction digits, second point,
      // missing operands, divide by zero, symbol 15, precedence.
      send_list('{9,9,9,9,9,9,9,9,9,9,9,9,9,9,9,9,9,9,9,9,9,9,13,9,9,9,9,9,9,9,9,9});
      send_list('{0,10,1,2,3,4,5,6,7,8,9,9,9,10,5});
      send_list('{13,11});
      send_list('{1,14,0,11,5,5});
      send_list('{15});
      send_list('{2,11,3,13,4,12,9,14,2});
      send_list('{0,10,0,0,0,0,0,0,0,0,1,13,0,10,0,0,0,0,0,0,0,0,1});
      send_list('{1,12,9,9,9,9,9,9,9,9,9,9,9,9,9,9,9,9,9,13,9,9,9,9,9,9,9,9,9,9});
      send_list('{7,14,3});

      for (int n = 0; n < 135; n++) begin
         if (n == 40) long_hold = 1;
         if ($urandom_range(0, 9) == 0) send_noise();
         else send_expression();
      end
      req_chan.valid <= 0;
      sending_done = 1;

      quiet = 0;
      while (pending_count != 0 && quiet < 100000) begin
         @(posedge clock);
         quiet++;
      end
      repeat (400) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
